// ===== rtl/dwf_pkg.sv =====
// Shared types and constants of the duplicate word filter.
package dwf_pkg;

    localparam int MAX_WORD    = 63;
    localparam int STORE_DEPTH = 1024;

    localparam int HASH_W  = 32;
    localparam int WLEN_W  = $clog2(MAX_WORD + 1);
    localparam int BUF_AW  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int GRP     = 32;
    localparam int NGRP    = (STORE_DEPTH + GRP - 1) / GRP;

    localparam int          HASH_SHIFT = 5;
    localparam logic [7:0]  WORD_LO    = 8'd33;
    localparam logic [7:0]  WORD_HI    = 8'd127;
    localparam logic [7:0]  SPACE_BYTE = 8'd32;
    localparam logic [7:0]  END_BYTE   = 8'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
        logic       word_truncated;
        logic       store_full;
    } t_out;

    // broadcast to every store cell
    typedef struct packed {
        logic              insert;
        logic [HASH_W-1:0] hash;
    } t_cell_cmd;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic              lt;
        logic [HASH_W-1:0] val;
    } t_link;

endpackage

// ===== rtl/dwf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dwf_cell.sv =====
// One entry of the sorted hash store: compare flags and shift-on-insert.
module dwf_cell (
    input  logic              i_clk,
    input  dwf_pkg::t_cell_cmd i_cmd,
    input  logic              i_occ,
    input  dwf_pkg::t_link    i_left,
    output dwf_pkg::t_link    o_link,
    output logic              o_eq
);
    import dwf_pkg::*;

    logic [HASH_W-1:0] r_val;
    logic [HASH_W-1:0] n_val;
    logic              r_lt;
    logic              r_eq;

    // entries below the insert point keep; the insert point takes the hash,
    // everything above takes its left neighbor
    always_comb begin
        n_val = r_val;
        if (i_cmd.insert && !r_lt) begin
            n_val = i_left.lt ? i_cmd.hash : i_left.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_lt  <= i_occ && (r_val < i_cmd.hash);
        r_eq  <= i_occ && (r_val == i_cmd.hash);
    end

    assign o_link = '{lt: r_lt, val: r_val};
    assign o_eq   = r_eq;
endmodule

// ===== rtl/duplicate_word_filter.sv =====
// Top level of the duplicate word filter: word buffer, hash, cell store, control.
// Word bytes and delimiters with no pending word are taken in the idle state. A
// delimiter or end ending a word passes the lookup states compare, reduce and decide;
// a new word then emits its bytes and a space, held by output stalls; a repeat emits nothing.
// Bare end (or end after a repeat) emits the end byte. All cells insert in parallel.
// Reset (synchronous, active low) empties the store and the pending word.
module duplicate_word_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dwf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dwf_pkg::t_out o_out_data
);
    import dwf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_DEC,
        S_EMIT,
        S_BARE
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [WLEN_W-1:0] r_len, n_len;
    logic [WLEN_W-1:0] r_idx, n_idx;
    logic              r_overlong, n_overlong;
    logic              r_at_end, n_at_end;
    logic              r_full, n_full;
    logic [NGRP-1:0]   r_grp;
    logic [NGRP-1:0]   c_grp;

    logic              accept;
    logic              ofree;
    logic              is_word;
    logic              store_full;
    logic              match;
    logic              insert;
    logic              buf_we;
    logic [7:0]        buf_rdata;

    t_cell_cmd         cell_cmd;
    t_link             head;
    t_link             w_link [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] w_eq;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign ofree      = !r_out_valid || !i_out_stall;
    assign is_word    = (i_in_data.in_byte >= WORD_LO) && (i_in_data.in_byte <= WORD_HI);
    assign store_full = r_count >= CNT_W'(STORE_DEPTH);
    assign match      = |r_grp;

    // ---- word buffer ----
    assign buf_we = accept && !i_in_data.end_of_text && is_word
                    && (r_len < WLEN_W'(MAX_WORD));

    dwf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_word_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_len[BUF_AW-1:0]),
        .i_wdata (i_in_data.in_byte),
        .i_raddr (n_idx[BUF_AW-1:0]),
        .o_rdata (buf_rdata)
    );

    // ---- sorted hash store ----
    assign cell_cmd = '{insert: insert, hash: r_hash};
    assign head     = '{lt: 1'b1, val: r_hash};

    for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
        t_link left;
        if (gi == 0) begin : g_first
            assign left = head;
        end else begin : g_rest
            assign left = w_link[gi-1];
        end
        dwf_cell u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cell_cmd),
            .i_occ  (IDX < r_count),
            .i_left (left),
            .o_link (w_link[gi]),
            .o_eq   (w_eq[gi])
        );
    end

    // first level of the match reduction, registered per group
    always_comb begin
        c_grp = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < STORE_DEPTH) begin
                    c_grp[g] = c_grp[g] | w_eq[g * GRP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= c_grp;
    end

    // ---- control ----
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_count     = r_count;
        n_hash      = r_hash;
        n_len       = r_len;
        n_idx       = r_idx;
        n_overlong  = r_overlong;
        n_at_end    = r_at_end;
        n_full      = r_full;
        insert      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.end_of_text) begin
                        n_at_end = 1'b1;
                        n_state  = (r_len != '0) ? S_CMP : S_BARE;
                    end else if (is_word) begin
                        n_hash = ((r_hash << HASH_SHIFT) + r_hash)
                                 ^ HASH_W'(i_in_data.in_byte);
                        if (r_len < WLEN_W'(MAX_WORD)) begin
                            n_len = r_len + 1'b1;
                        end else begin
                            n_overlong = 1'b1;
                        end
                    end else if (r_len != '0) begin
                        n_at_end = 1'b0;
                        n_state  = S_CMP;
                    end
                end
            end
            S_CMP: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (!match) begin
                    insert = !store_full;
                    if (!store_full) begin
                        n_count = r_count + 1'b1;
                    end
                    n_full  = store_full;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_hash     = '0;
                    n_len      = '0;
                    n_overlong = 1'b0;
                    n_state    = r_at_end ? S_BARE : S_IDLE;
                end
            end
            S_EMIT: begin
                if (ofree) begin
                    n_out_valid          = 1'b1;
                    n_out.word_truncated = r_overlong;
                    n_out.store_full     = r_full;
                    if (r_idx == r_len) begin
                        n_out.out_byte = SPACE_BYTE;
                        n_out.run_last = 1'b1;
                        n_out.text_end = r_at_end;
                        n_hash         = '0;
                        n_len          = '0;
                        n_overlong     = 1'b0;
                        if (r_at_end) begin
                            n_count = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_out.out_byte = buf_rdata;
                        n_out.run_last = 1'b0;
                        n_out.text_end = 1'b0;
                        n_idx          = r_idx + 1'b1;
                    end
                end
            end
            S_BARE: begin
                if (ofree) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: END_BYTE, run_last: 1'b1, text_end: 1'b1,
                                    word_truncated: 1'b0, store_full: 1'b0};
                    n_count     = '0;
                    n_hash      = '0;
                    n_len       = '0;
                    n_overlong  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_hash      <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_overlong  <= 1'b0;
            r_at_end    <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_hash      <= n_hash;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_overlong  <= n_overlong;
            r_at_end    <= n_at_end;
            r_full      <= n_full;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    // checked when the end item first shows up; a stalled one may see new inserts
    a_end_clears_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid && o_out_data.text_end) |-> (r_count == '0))
        else $error("store not cleared at end of text");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.text_end) |-> o_out_data.run_last)
        else $error("end of text without run_last");

    a_store_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_link[0].val < w_link[1].val))
        else $error("hash store out of order");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && store_full) |=> (r_count == $past(r_count)))
        else $error("full store grew");
endmodule

// ===== sim/duplicate_word_filter_tb.sv =====
// Testbench for duplicate_word_filter: random and directed text against a built-in predictor.
module duplicate_word_filter_tb;
    import dwf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam int POOL         = 16;
    localparam int POOL_MAX_LEN = 80;

    class dedup_checker;
        t_out        pending_bytes[$];
        bit          stored_hashes[logic [HASH_W-1:0]];
        logic [31:0] word_hash;
        logic [7:0]  word_bytes[MAX_WORD];
        int          word_len;
        bit          word_long;
        int          mismatches;

        function new();
            word_hash  = '0;
            word_len   = 0;
            word_long  = 1'b0;
            mismatches = 0;
        endfunction

        function void push_result(logic [7:0] b, logic last, logic at_end,
                                  logic trunc, logic full);
            t_out r;
            r.out_byte       = b;
            r.run_last       = last;
            r.text_end       = at_end;
            r.word_truncated = trunc;
            r.store_full     = full;
            pending_bytes.push_back(r);
        endfunction

        // returns the number of results the pending word produces
        function int flush_word(bit at_end);
            bit full;
            int n;
            n = 0;
            if (word_len == 0)
                return 0;
            if (!stored_hashes.exists(word_hash)) begin
                full = (stored_hashes.num() >= STORE_DEPTH);
                if (!full)
                    stored_hashes[word_hash] = 1'b1;
                for (int i = 0; i < word_len; i++)
                    push_result(word_bytes[i], 1'b0, 1'b0, word_long, full);
                push_result(SPACE_BYTE, 1'b1, at_end, word_long, full);
                n = word_len + 1;
            end
            word_hash = '0;
            word_len  = 0;
            word_long = 1'b0;
            return n;
        endfunction

        function void predict_item(t_in item);
            if (item.end_of_text) begin
                if (flush_word(1'b1) == 0)
                    push_result(END_BYTE, 1'b1, 1'b1, 1'b0, 1'b0);
                stored_hashes.delete();
            end else if (item.in_byte >= WORD_LO && item.in_byte <= WORD_HI) begin
                word_hash = ((word_hash << HASH_SHIFT) + word_hash) ^ {24'b0, item.in_byte};
                if (word_len < MAX_WORD) begin
                    word_bytes[word_len] = item.in_byte;
                    word_len++;
                end else begin
                    word_long = 1'b1;
                end
            end else begin
                void'(flush_word(1'b0));
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = pending_bytes.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
            compare_field("text_end", 8'(want.text_end), 8'(got.text_end));
            compare_field("word_truncated", 8'(want.word_truncated), 8'(got.word_truncated));
            compare_field("store_full", 8'(want.store_full), 8'(got.store_full));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    dedup_checker dedup = new();
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    logic [7:0] pool_bytes[POOL][POOL_MAX_LEN];
    int         pool_len[POOL];
    int         pool_used;

    duplicate_word_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // input is noted before the output check so same-edge results still find it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                dedup.predict_item(i_in_data);
            if (o_out_valid && !i_out_stall)
                dedup.check_result(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("duplicate_word_filter_tb: FAIL");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in item;
        item.in_byte     = b;
        item.end_of_text = 1'b0;
        send_item(item);
    endtask

    task automatic send_end();
        t_in item;
        item.in_byte     = 8'($urandom_range(255));
        item.end_of_text = 1'b1;
        send_item(item);
    endtask

    function automatic logic [7:0] random_delim();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(32));
        return 8'($urandom_range(255, 128));
    endfunction

    task automatic send_pool_word(input int idx);
        for (int i = 0; i < pool_len[idx]; i++)
            send_byte(pool_bytes[idx][i]);
    endtask

    task automatic random_text(input int n_items);
        int sent;
        int idx;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                send_end();
                sent++;
            end else if (pick <= 2) begin
                send_byte(random_delim());
                sent++;
            end else begin
                if (pick <= 5 && pool_used > 0) begin
                    idx = $urandom_range(pool_used - 1);
                end else begin
                    if (pool_used < POOL) begin
                        idx = pool_used;
                        pool_used++;
                    end else begin
                        idx = $urandom_range(POOL - 1);
                    end
                    // mostly short words, now and then one near or past the buffer size
                    pool_len[idx] = ($urandom_range(15) == 0) ?
                                    $urandom_range(POOL_MAX_LEN, MAX_WORD - 1) :
                                    $urandom_range(6, 1);
                    for (int i = 0; i < pool_len[idx]; i++)
                        pool_bytes[idx][i] = 8'($urandom_range(WORD_HI, WORD_LO));
                end
                send_pool_word(idx);
                sent += pool_len[idx];
                if ($urandom_range(4) != 0) begin
                    send_byte(random_delim());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [7:0] long_word[MAX_WORD + 1];

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pool_used      = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // boundaries of the word range, every delimiter class, duplicates, end of text
        send_byte(WORD_LO);
        send_byte(WORD_HI);
        send_byte(SPACE_BYTE);
        send_byte(8'd0);
        send_byte(WORD_LO);
        send_byte(WORD_HI);
        send_byte(8'd255);
        send_byte(8'h41);
        send_byte(8'd128);
        send_byte(8'h42);
        send_byte(8'd1);
        send_end();
        send_byte(WORD_LO);
        send_byte(WORD_HI);
        send_byte(SPACE_BYTE);
        send_byte(8'h41);
        send_end();
        send_byte(8'h41);
        send_byte(8'd9);
        send_byte(8'h41);
        send_end();
        send_end();

        // word that just fits, then the same bytes plus one more (overlong, new hash)
        for (int i = 0; i <= MAX_WORD; i++)
            long_word[i] = 8'($urandom_range(WORD_HI, WORD_LO));
        for (int i = 0; i < MAX_WORD; i++)
            send_byte(long_word[i]);
        send_byte(SPACE_BYTE);
        for (int i = 0; i <= MAX_WORD; i++)
            send_byte(long_word[i]);
        send_end();

        send_idle_pct = 0;  recv_stall_pct = 0;
        random_text(30);
        send_idle_pct = 81; recv_stall_pct = 0;
        random_text(30);
        send_idle_pct = 0;  recv_stall_pct = 81;
        random_text(30);
        send_idle_pct = 31; recv_stall_pct = 31;
        random_text(30);
        send_end();

        i_in_valid <= 1'b0;
        while (dedup.pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dedup.mismatches == 0)
            $display("duplicate_word_filter_tb: PASS");
        else
            $display("duplicate_word_filter_tb: FAIL");
        $finish;
    end

endmodule
